// ===== design/prq_pkg.sv =====
// shared constants and types for the quaternion point rotation pipeline
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

    // default field formats: point signed Q16.16, quaternion signed Q2.30
    localparam int unsigned PRQ_COORD_WIDTH     = 32;
    localparam int unsigned PRQ_QUAT_WIDTH      = 32;
    localparam int unsigned PRQ_QUAT_FRAC_BITS  = 30;

    // register stages from input to output register
    localparam int unsigned PRQ_STAGES = 6;

    typedef logic [PRQ_STAGES-1:0] t_stage_vec;

endpackage

`default_nettype wire

// ===== design/point_rotate_by_quaternion.sv =====
// top level: streaming rotation of a 3d point by a quaternion, q * (0, v) * conj(q)
`timescale 1ns / 1ps
`default_nettype none

// Rotates one point per request by the quaternion that comes with it and returns
// the vector part of q * (0, x, y, z) * conj(q). The block takes one request every
// clock cycle while the output side does not stall, and each result passes through
// the registered stages of the arithmetic pipeline
// (pairwise quaternion products, rotation matrix, split matrix-vector products,
// axis sums, rounding, saturation). Every stage holds its own valid bit and
// advances whenever the stage after it is empty or moving, so a stall at the
// output fills the bubbles first and only then stops the input side; nothing is
// lost or repeated. The result is exact and rounded once, half toward plus
// infinity, to the point format. A quaternion that is not of unit length scales
// the point by its squared norm. An axis that leaves the signed coordinate range
// is clipped to the nearest bound and tuser bit 0 is then set. The block keeps no
// state between requests. QUAT_FRAC_BITS is expected below QUAT_WIDTH + 2.
module point_rotate_by_quaternion #(
    parameter int unsigned COORD_WIDTH    = prq_pkg::PRQ_COORD_WIDTH,
    parameter int unsigned QUAT_WIDTH     = prq_pkg::PRQ_QUAT_WIDTH,
    parameter int unsigned QUAT_FRAC_BITS = prq_pkg::PRQ_QUAT_FRAC_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // request side
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // point_x, point_y, point_z, quat_w, quat_i, quat_j, quat_k, zero fill
    input  wire logic [((3*COORD_WIDTH+4*QUAT_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // result side
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // rotated_x, rotated_y, rotated_z, zero fill
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // saturated
    output logic [0:0] o_m_tuser
);
    import prq_pkg::*;

    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned QW  = QUAT_WIDTH;
    localparam int unsigned PW  = 2*QW;          // quaternion pair product
    localparam int unsigned MW  = PW + 2;        // matrix entry, up to 2 * (sum of 2 products)
    localparam int unsigned LW  = QW + 1 + CW;   // low-half entry times point
    localparam int unsigned HW  = QW + 2 + CW;   // high-half entry times point
    localparam int unsigned LSW = LW + 2;        // sum of three low products
    localparam int unsigned HSW = HW + 2;        // sum of three high products
    localparam int unsigned TW  = 2*QW + CW + 5; // full axis sum with rounding
    localparam int unsigned RS  = 2*QUAT_FRAC_BITS;
    localparam int unsigned UW  = TW - RS - CW + 1;

    localparam logic signed [TW-1:0] HALF   = TW'(1) <<< (RS - 1);
    localparam logic [CW-1:0]        AX_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        AX_MIN = {1'b1, {(CW-1){1'b0}}};

    // ------------------------------------------------------------------
    // stage control: a stage loads when it is empty or its data moves on
    // ------------------------------------------------------------------
    t_stage_vec r_vld;
    t_stage_vec stg_en;

    always_comb begin
        stg_en[PRQ_STAGES-1] = !r_vld[PRQ_STAGES-1] || i_m_tready;
        for (int k = PRQ_STAGES - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < PRQ_STAGES; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = stg_en[0];
    assign o_m_tvalid = r_vld[PRQ_STAGES-1];

    // ------------------------------------------------------------------
    // unpack request fields
    // ------------------------------------------------------------------
    logic signed [CW-1:0] in_p [3];
    logic signed [QW-1:0] in_qw, in_qi, in_qj, in_qk;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            in_p[c] = signed'(i_s_tdata[c*CW +: CW]);
        end
        in_qw = signed'(i_s_tdata[3*CW        +: QW]);
        in_qi = signed'(i_s_tdata[3*CW + QW   +: QW]);
        in_qj = signed'(i_s_tdata[3*CW + 2*QW +: QW]);
        in_qk = signed'(i_s_tdata[3*CW + 3*QW +: QW]);
    end

    // ------------------------------------------------------------------
    // stage 1: the ten pairwise quaternion products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r1_ww, r1_ii, r1_jj, r1_kk;
    logic signed [PW-1:0] r1_wi, r1_wj, r1_wk, r1_ij, r1_ik, r1_jk;
    logic signed [CW-1:0] r1_p [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r1_ww <= PW'(in_qw) * PW'(in_qw);
            r1_ii <= PW'(in_qi) * PW'(in_qi);
            r1_jj <= PW'(in_qj) * PW'(in_qj);
            r1_kk <= PW'(in_qk) * PW'(in_qk);
            r1_wi <= PW'(in_qw) * PW'(in_qi);
            r1_wj <= PW'(in_qw) * PW'(in_qj);
            r1_wk <= PW'(in_qw) * PW'(in_qk);
            r1_ij <= PW'(in_qi) * PW'(in_qj);
            r1_ik <= PW'(in_qi) * PW'(in_qk);
            r1_jk <= PW'(in_qj) * PW'(in_qk);
            r1_p  <= in_p;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: rotation matrix, entry r*3+c maps point axis c to result axis r
    // q v q* = (w^2 - u.u) v + 2 (u.v) u + 2 w (u x v), exact for any q
    // ------------------------------------------------------------------
    logic signed [MW-1:0] r2_m [9];
    logic signed [CW-1:0] r2_p [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r2_m[0] <= MW'(r1_ww) + MW'(r1_ii) - MW'(r1_jj) - MW'(r1_kk);
            r2_m[1] <= (MW'(r1_ij) - MW'(r1_wk)) <<< 1;
            r2_m[2] <= (MW'(r1_ik) + MW'(r1_wj)) <<< 1;
            r2_m[3] <= (MW'(r1_ij) + MW'(r1_wk)) <<< 1;
            r2_m[4] <= MW'(r1_ww) - MW'(r1_ii) + MW'(r1_jj) - MW'(r1_kk);
            r2_m[5] <= (MW'(r1_jk) - MW'(r1_wi)) <<< 1;
            r2_m[6] <= (MW'(r1_ik) - MW'(r1_wj)) <<< 1;
            r2_m[7] <= (MW'(r1_jk) + MW'(r1_wi)) <<< 1;
            r2_m[8] <= MW'(r1_ww) - MW'(r1_ii) - MW'(r1_jj) + MW'(r1_kk);
            r2_p    <= r1_p;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: each entry split into an unsigned low half and a signed
    // high half, each multiplied by its point axis
    // ------------------------------------------------------------------
    logic signed [QW:0]   s3_ml [9];
    logic signed [QW+1:0] s3_mh [9];
    logic signed [LW-1:0] r3_lo [9];
    logic signed [HW-1:0] r3_hi [9];

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            s3_ml[e] = signed'({1'b0, r2_m[e][QW-1:0]});
            s3_mh[e] = signed'(r2_m[e][MW-1:QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r3_lo[r*3+c] <= LW'(s3_ml[r*3+c]) * LW'(r2_p[c]);
                    r3_hi[r*3+c] <= HW'(s3_mh[r*3+c]) * HW'(r2_p[c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: per axis sums of the low and the high products
    // ------------------------------------------------------------------
    logic signed [LSW-1:0] r4_lo [3];
    logic signed [HSW-1:0] r4_hi [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            for (int r = 0; r < 3; r++) begin
                r4_lo[r] <= LSW'(r3_lo[r*3]) + LSW'(r3_lo[r*3+1]) + LSW'(r3_lo[r*3+2]);
                r4_hi[r] <= HSW'(r3_hi[r*3]) + HSW'(r3_hi[r*3+1]) + HSW'(r3_hi[r*3+2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: recombine the halves and add the rounding constant
    // ------------------------------------------------------------------
    logic signed [TW-1:0] r5_sum [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            for (int r = 0; r < 3; r++) begin
                r5_sum[r] <= (TW'(r4_hi[r]) <<< QW) + TW'(r4_lo[r]) + HALF;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: drop fraction bits, clip to the coordinate range
    // ------------------------------------------------------------------
    logic [UW-1:0] s6_up   [3];
    logic [2:0]    s6_fits;
    logic [CW-1:0] s6_axis [3];
    logic [CW-1:0] r6_axis [3];
    logic          r6_sat;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            // bits above the result sign must all copy it
            s6_up[r]   = r5_sum[r][TW-1:RS+CW-1];
            s6_fits[r] = (&s6_up[r]) || !(|s6_up[r]);
            if (s6_fits[r]) begin
                s6_axis[r] = r5_sum[r][RS +: CW];
            end else if (r5_sum[r][TW-1]) begin
                s6_axis[r] = AX_MIN;
            end else begin
                s6_axis[r] = AX_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r6_axis <= s6_axis;
            r6_sat  <= !(&s6_fits);
        end
    end

    always_comb begin
        o_m_tdata = '0;
        for (int r = 0; r < 3; r++) begin
            o_m_tdata[r*CW +: CW] = r6_axis[r];
        end
    end

    assign o_m_tuser[0] = r6_sat;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // an accepted request always occupies the first stage next cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    // the stage 5 sums of axes 0 and 2 keep their data while stage 6 cannot take them
    a_hold_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !stg_en[5]) |=> $stable(r5_sum[0]) && $stable(r5_sum[2]))
        else $error("stalled stage lost its data");

    // a saturation flag always comes with at least one axis on a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |->
            (r6_axis[0] == AX_MAX || r6_axis[0] == AX_MIN ||
             r6_axis[1] == AX_MAX || r6_axis[1] == AX_MIN ||
             r6_axis[2] == AX_MAX || r6_axis[2] == AX_MIN))
        else $error("saturation flagged with no clipped axis");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the quaternion point rotation stream block
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CW      = prq_pkg::PRQ_COORD_WIDTH;
    localparam int unsigned QW      = prq_pkg::PRQ_QUAT_WIDTH;
    localparam int unsigned QFB     = prq_pkg::PRQ_QUAT_FRAC_BITS;
    localparam int unsigned LATENCY = prq_pkg::PRQ_STAGES;
    localparam int unsigned IN_W    = ((3*CW + 4*QW + 7) / 8) * 8;
    localparam int unsigned OUT_W   = ((3*CW + 7) / 8) * 8;
    localparam int unsigned RANDOM_REQUESTS = 1250;
    localparam int unsigned STALL_LIMIT     = 2000;

    // one q2.30 unit
    localparam logic [31:0] Q_ONE     = 32'h4000_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hc000_0000;
    // cos 45 deg in q2.30
    localparam logic [31:0] Q_COS45   = 32'd759250125;
    localparam logic [31:0] P_ONE     = 32'h0001_0000;
    localparam logic [31:0] W_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN     = 32'h8000_0000;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 sat;
    } t_rotated_point;

    class rotation_scoreboard;
        t_rotated_point expected_points[$];
        int unsigned    mismatches = 0;

        // round half up to the point format, then clip to the signed range
        function logic [CW:0] finish_axis(t_wide acc);
            t_wide half;
            t_wide scaled;
            half = '0;
            half[2*QFB-1] = 1'b1;
            scaled = (acc + half) >>> (2*QFB);
            if (&scaled[255:CW-1] || ~|scaled[255:CW-1])
                return {1'b0, scaled[CW-1:0]};
            return {1'b1, scaled[255], {(CW-1){~scaled[255]}}};
        endfunction

        // exact q * (0, v) * conj(q), vector part only
        function t_rotated_point rotate_point(logic [IN_W-1:0] req);
            t_wide px, py, pz, qw, qi, qj, qk, ci, cj, ck;
            t_wide t0, t1, t2, t3, r1, r2, r3;
            logic [CW:0] axis;
            t_rotated_point res;
            px = $signed(req[0*CW +: CW]);
            py = $signed(req[1*CW +: CW]);
            pz = $signed(req[2*CW +: CW]);
            qw = $signed(req[3*CW + 0*QW +: QW]);
            qi = $signed(req[3*CW + 1*QW +: QW]);
            qj = $signed(req[3*CW + 2*QW +: QW]);
            qk = $signed(req[3*CW + 3*QW +: QW]);
            ci = -qi;
            cj = -qj;
            ck = -qk;
            // first product, point has no real part
            t0 = -(qi * px) - (qj * py) - (qk * pz);
            t1 = (qw * px) + (qj * pz) - (qk * py);
            t2 = (qw * py) - (qi * pz) + (qk * px);
            t3 = (qw * pz) + (qi * py) - (qj * px);
            // second product with the conjugate
            r1 = (t0 * ci) + (t1 * qw) + (t2 * ck) - (t3 * cj);
            r2 = (t0 * cj) - (t1 * ck) + (t2 * qw) + (t3 * ci);
            r3 = (t0 * ck) + (t1 * cj) - (t2 * ci) + (t3 * qw);
            axis = finish_axis(r1);
            res.x = axis[CW-1:0];
            res.sat = axis[CW];
            axis = finish_axis(r2);
            res.y = axis[CW-1:0];
            res.sat |= axis[CW];
            axis = finish_axis(r3);
            res.z = axis[CW-1:0];
            res.sat |= axis[CW];
            return res;
        endfunction

        function void note_request(logic [IN_W-1:0] req);
            expected_points.push_back(rotate_point(req));
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic [0:0] user);
            t_rotated_point want;
            t_rotated_point got;
            if (expected_points.size() == 0) begin
                $error("result with no request pending: tdata %h tuser %b", data, user);
                mismatches++;
                return;
            end
            want = expected_points.pop_front();
            got.x = data[0*CW +: CW];
            got.y = data[1*CW +: CW];
            got.z = data[2*CW +: CW];
            got.sat = user[0];
            if (got.x !== want.x) begin
                $error("rotated_x: expected %0d, actual %0d", want.x, got.x);
                mismatches++;
            end
            if (got.y !== want.y) begin
                $error("rotated_y: expected %0d, actual %0d", want.y, got.y);
                mismatches++;
            end
            if (got.z !== want.z) begin
                $error("rotated_z: expected %0d, actual %0d", want.z, got.z);
                mismatches++;
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %0d, actual %0d", want.sat, got.sat);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b1;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0]       m_tuser;

    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    rotation_scoreboard rotations = new;

    point_rotate_by_quaternion u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic [IN_W-1:0] pack_request(logic [31:0] px, logic [31:0] py,
            logic [31:0] pz, logic [31:0] qw, logic [31:0] qi, logic [31:0] qj,
            logic [31:0] qk);
        logic [IN_W-1:0] req;
        req = '0;
        req[0*CW +: CW] = px;
        req[1*CW +: CW] = py;
        req[2*CW +: CW] = pz;
        req[3*CW + 0*QW +: QW] = qw;
        req[3*CW + 1*QW +: QW] = qi;
        req[3*CW + 2*QW +: QW] = qj;
        req[3*CW + 3*QW +: QW] = qk;
        return req;
    endfunction

    function automatic logic [IN_W-1:0] noise_request();
        logic [IN_W-1:0] req;
        for (int n = 0; n < IN_W; n += 32)
            req[n +: 32] = $urandom;
        return req;
    endfunction

    // random word of random magnitude
    function automatic logic [31:0] scaled_word();
        logic signed [31:0] w;
        w = $urandom;
        return w >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return W_MAX;
            4: return W_MIN;
            5: return Q_ONE;
            6: return Q_NEG_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic real unit_real();
        return real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0;
    endfunction

    function automatic logic [31:0] quat_part(real v);
        return $rtoi(v * (2.0 ** QFB));
    endfunction

    function automatic logic [IN_W-1:0] build_random_request();
        logic [IN_W-1:0] req;
        real q[4];
        real norm;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        req = '0;
        for (int n = 0; n < 3; n++)
            req[n*CW +: CW] = scaled_word();
        if (kind < 5) begin
            // proper rotation: normalized random quaternion
            for (int n = 0; n < 4; n++)
                q[n] = unit_real();
            norm = $sqrt(q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3]);
            if (norm < 0.001) begin
                q[0] = 1.0;
                q[1] = 0.0;
                q[2] = 0.0;
                q[3] = 0.0;
                norm = 1.0;
            end
            for (int n = 0; n < 4; n++)
                req[3*CW + n*QW +: QW] = quat_part(q[n] / norm);
        end else if (kind < 7) begin
            for (int n = 0; n < 4; n++)
                req[3*CW + n*QW +: QW] = scaled_word();
        end else if (kind < 9) begin
            for (int n = 0; n < 7; n++)
                req[n*32 +: 32] = corner_word();
        end else begin
            req = noise_request();
        end
        return req;
    endfunction

    task automatic send_request(input logic [IN_W-1:0] req);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            s_tdata  <= noise_request();
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge clk); while (!s_tready);
        rotations.note_request(req);
    endtask

    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
            input logic [31:0] pz, input logic [31:0] qw, input logic [31:0] qi,
            input logic [31:0] qj, input logic [31:0] qk);
        send_request(pack_request(px, py, pz, qw, qi, qj, qk));
    endtask

    // result side: check on handshake, then pick next ready
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                rotations.check_result(m_tdata, m_tuser);
            if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL point_rotate_by_quaternion");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // identity and sign-flipped identity
        send_point(P_ONE, 2*P_ONE, 3*P_ONE, Q_ONE, 0, 0, 0);
        send_point(W_MAX, W_MIN, '1, Q_ONE, 0, 0, 0);
        send_point(W_MIN, W_MAX, 32'd1, Q_NEG_ONE, 0, 0, 0);
        // zero quaternion gives zero everywhere
        send_point(W_MAX, W_MAX, W_MIN, 0, 0, 0, 0);
        // all-max and all-min fields, heavy overflow
        send_point(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
        send_point(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
        // quarter turns about z and about x, inexact so rounding matters
        send_point(P_ONE, 0, 0, Q_COS45, 0, 0, Q_COS45);
        send_point(0, -P_ONE, P_ONE, Q_COS45, Q_COS45, 0, 0);
        // half turns about each axis
        send_point(P_ONE, 2*P_ONE, 3*P_ONE, 0, Q_ONE, 0, 0);
        send_point(P_ONE, 2*P_ONE, 3*P_ONE, 0, 0, Q_ONE, 0);
        send_point(P_ONE, 2*P_ONE, 3*P_ONE, 0, 0, 0, Q_ONE);
        // w = -2.0 scales by four: positive bound overflows, negative bound fits
        send_point(32'h2000_0000, 32'he000_0000, 32'd1, W_MIN, 0, 0, 0);
        send_point(32'h1fff_ffff, 32'he000_0000, '1, W_MIN, 0, 0, 0);
        // exact halves round toward plus infinity, quarters to nearest
        send_point(32'd2, -32'sd2, 32'd1, 32'h2000_0000, 0, 0, 0);
        send_point(32'd3, -32'sd3, '1, 32'h2000_0000, 0, 0, 0);
        // non-unit quaternions scale by the squared norm
        send_point(P_ONE, -P_ONE, P_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        send_point(W_MAX, 0, 0, 32'h2000_0000, 0, 0, 0);
        send_point(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, Q_ONE, Q_ONE, 0, 0);
        // negative bound: a single clipped axis, then two axes that fit
        send_point(W_MIN, 0, 0, Q_COS45, 0, 0, Q_COS45);
        send_point(W_MIN, W_MIN, 0, Q_ONE, 0, 0, 0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0)
                idle_on = (n < RANDOM_REQUESTS - 150) ? ($urandom_range(0, 3) != 0) : 1'b0;
            send_request(build_random_request());
        end
        s_tvalid <= 1'b0;

        while (rotations.expected_points.size() != 0)
            @(posedge clk);
        repeat (4*LATENCY) @(posedge clk);
        if (rotations.mismatches == 0 && rotations.expected_points.size() == 0) begin
            $display("PASS point_rotate_by_quaternion");
        end else begin
            $display("FAIL point_rotate_by_quaternion");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/prq_pkg.sv
design/point_rotate_by_quaternion.sv
test/testbench.sv
